// File: hdl/hpid_pkg.sv
package hpid_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_TARGET   = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_STOP_THR = 3'd4
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 16;

    // Controller constants.
    localparam logic [3:0]         SETTLE_TICKS   = 4'd10;
    localparam logic [3:0]         TICK_MAX       = 4'd15;
    localparam logic signed [14:0] CLEAR_LIMIT    = 15'sd800;
    localparam logic [23:0]        INTEGRAL_MAX   = 24'hFFFFFF;
    localparam logic [14:0]        STOP_THR_RESET = 15'd26;
    // 0.88 as a Q16 factor.
    localparam logic signed [16:0] SCALE_088      = 17'sd57672;
    // Any speed beyond this saturates the drive anyway.
    localparam logic signed [16:0] SPEED_LIM      = 17'sd65535;
    localparam logic signed [16:0] SPEED_LIM_NEG  = -17'sd65535;
    localparam logic signed [15:0] DRIVE_MAX      = 16'sd25600;
    localparam logic signed [15:0] DRIVE_MIN      = -16'sd25600;

    typedef struct packed {
        logic signed [13:0] target;
        logic [15:0]        gain_p;
        logic [15:0]        gain_i;
        logic [15:0]        gain_d;
        logic [14:0]        stop_thr;
    } cfg_t;

    // Error terms of one sample.
    typedef struct packed {
        logic signed [14:0] err;
        logic signed [15:0] deriv;
        logic [23:0]        integral;
        logic               restart;
        logic               settled;
    } front_t;

    // Weighted terms of one sample.
    typedef struct packed {
        logic signed [31:0] p_err;
        logic [39:0]        p_int;
        logic signed [31:0] p_der;
        logic               restart;
        logic               settled;
    } prod_t;

endpackage

// File: hdl/hpid_if.sv
interface hpid_in_if;
    logic        valid;
    logic        ready;
    logic [12:0] heading;
    logic        restart;

    modport source (output valid, output heading, output restart, input ready);
    modport sink (input valid, input heading, input restart, output ready);
endinterface

interface hpid_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;
    logic               stopped;

    modport source (output valid, output drive, output stopped, input ready);
    modport sink (input valid, input drive, input stopped, output ready);
endinterface

// File: hdl/heading_pid_turn_controller_top.sv
// Heading PID turn controller. Each request carries a heading sample (Q4
// degrees) and a restart flag and yields one result: a signed drive in
// 1/256 percent and the stop flag. The error to the target heading feeds a
// PID sum with unsigned Q8.8 gains; the integral is cleared whenever the
// error is not positive or reaches 50 degrees, and once ten samples have
// passed a speed below the stop threshold latches a stop (drive 0) until a
// restart. One sample is taken per clock cycle unless result_ch.ready stalls it;
// the four register stages are input and error terms, the three gain multipliers,
// the speed sum with the stop check, and the 0.88 scaling with saturation.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must do
// so only while no sample is in flight (the block does not enforce it). Indexes 0
// to 4 are target heading, P, I, D gains, stop threshold; other indexes are ignored.
module heading_pid_turn_controller_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [hpid_pkg::CFG_DATA_W-1:0]   cfg_data,
    hpid_in_if.sink                           sample_ch,
    hpid_out_if.source                        result_ch
);

    hpid_pkg::cfg_t   cfg_reg;
    logic             s1_valid;
    logic             s1_ready;
    hpid_pkg::front_t s1_data;
    logic             s2_valid;
    logic             s2_ready;
    hpid_pkg::prod_t  s2_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target   <= '0;
            cfg_reg.gain_p   <= '0;
            cfg_reg.gain_i   <= '0;
            cfg_reg.gain_d   <= '0;
            cfg_reg.stop_thr <= hpid_pkg::STOP_THR_RESET;
        end
        else if (cfg_we)
        begin
            case (hpid_pkg::cfg_index_t'(cfg_index))
                hpid_pkg::REG_TARGET:   cfg_reg.target   <= $signed(cfg_data[13:0]);
                hpid_pkg::REG_GAIN_P:   cfg_reg.gain_p   <= cfg_data;
                hpid_pkg::REG_GAIN_I:   cfg_reg.gain_i   <= cfg_data;
                hpid_pkg::REG_GAIN_D:   cfg_reg.gain_d   <= cfg_data;
                hpid_pkg::REG_STOP_THR: cfg_reg.stop_thr <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    hpid_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .sample_ch (sample_ch),
        .s1_valid  (s1_valid),
        .s1_data   (s1_data),
        .s1_ready  (s1_ready)
    );

    hpid_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s1_ready (s1_ready),
        .s2_valid (s2_valid),
        .s2_data  (s2_data),
        .s2_ready (s2_ready)
    );

    hpid_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s2_valid  (s2_valid),
        .s2_data   (s2_data),
        .s2_ready  (s2_ready),
        .result_ch (result_ch)
    );

endmodule

// File: hdl/hpid_front.sv
module hpid_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hpid_pkg::cfg_t       cfg,
    hpid_in_if.sink              sample_ch,
    output logic                 s1_valid,
    output hpid_pkg::front_t     s1_data,
    input  logic                 s1_ready
);

    logic signed [14:0] prev_err_reg;
    logic [23:0]        integral_reg;
    logic [3:0]         tick_reg;
    logic               s1_valid_reg;
    hpid_pkg::front_t   s1_data_reg;

    logic signed [14:0] prev_base;
    logic [23:0]        integral_base;
    logic [3:0]         tick_base;
    logic signed [14:0] err;
    logic signed [15:0] deriv;
    logic [24:0]        int_sum;
    logic               int_clear;
    logic [23:0]        integral_next;
    logic [3:0]         tick_next;
    logic               accept;

    assign sample_ch.ready = !s1_valid_reg || s1_ready;
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign s1_valid        = s1_valid_reg;
    assign s1_data         = s1_data_reg;

    // Error, derivative and integral of the incoming sample. A restart
    // replaces the stored state before the sample is used. State written
    // after a stop has latched is still read, but the drive stays 0 until a restart.
    always_comb
    begin
        prev_base     = sample_ch.restart ? {cfg.target[13], cfg.target} : prev_err_reg;
        integral_base = sample_ch.restart ? 24'd0 : integral_reg;
        tick_base     = sample_ch.restart ? 4'd0 : tick_reg;
        err           = {cfg.target[13], cfg.target} - $signed({2'b00, sample_ch.heading});
        deriv         = {err[14], err} - {prev_base[14], prev_base};
        int_clear     = (err <= 15'sd0) || (err >= hpid_pkg::CLEAR_LIMIT);
        int_sum       = {1'b0, integral_base} + {10'd0, err};
        if (int_clear)
        begin
            integral_next = 24'd0;
        end
        else if (int_sum[24])
        begin
            integral_next = hpid_pkg::INTEGRAL_MAX;
        end
        else
        begin
            integral_next = int_sum[23:0];
        end
        tick_next = (tick_base < hpid_pkg::TICK_MAX) ? tick_base + 4'd1 : tick_base;
    end

    // Controller state and the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            integral_reg <= '0;
            tick_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            prev_err_reg <= err;
            integral_reg <= integral_next;
            tick_reg     <= tick_next;
            s1_valid_reg <= 1'b1;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg.err      <= err;
            s1_data_reg.deriv    <= deriv;
            s1_data_reg.integral <= integral_next;
            s1_data_reg.restart  <= sample_ch.restart;
            s1_data_reg.settled  <= tick_base >= hpid_pkg::SETTLE_TICKS;
        end
    end

endmodule

// File: hdl/hpid_mult.sv
module hpid_mult (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hpid_pkg::cfg_t       cfg,
    input  logic                 s1_valid,
    input  hpid_pkg::front_t     s1_data,
    output logic                 s1_ready,
    output logic                 s2_valid,
    output hpid_pkg::prod_t      s2_data,
    input  logic                 s2_ready
);

    logic            s2_valid_reg;
    hpid_pkg::prod_t s2_data_reg;
    logic            load;

    assign s1_ready = !s2_valid_reg || s2_ready;
    assign load     = s1_valid && s1_ready;
    assign s2_valid = s2_valid_reg;
    assign s2_data  = s2_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    // Three gain multipliers in parallel.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_data_reg.p_err   <= $signed({1'b0, cfg.gain_p}) * s1_data.err;
            s2_data_reg.p_int   <= {24'd0, cfg.gain_i} * {16'd0, s1_data.integral};
            s2_data_reg.p_der   <= $signed({1'b0, cfg.gain_d}) * s1_data.deriv;
            s2_data_reg.restart <= s1_data.restart;
            s2_data_reg.settled <= s1_data.settled;
        end
    end

endmodule

// File: hdl/hpid_out.sv
module hpid_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hpid_pkg::cfg_t       cfg,
    input  logic                 s2_valid,
    input  hpid_pkg::prod_t      s2_data,
    output logic                 s2_ready,
    hpid_out_if.source           result_ch
);

    logic                stop_reg;
    logic                s3_valid_reg;
    logic signed [16:0]  speed_reg;
    logic                zero_reg;
    logic                out_valid_reg;
    logic signed [15:0]  drive_reg;
    logic                stopped_reg;

    logic                s3_ready;
    logic                load3;
    logic                load4;
    logic signed [41:0]  raw;
    logic signed [37:0]  speed;
    logic signed [16:0]  speed_clamped;
    logic                latch_base;
    logic                fire;
    logic                zero_next;
    logic signed [33:0]  scaled_full;
    logic signed [16:0]  scaled;
    logic signed [15:0]  drive_next;

    assign s3_ready         = !out_valid_reg || result_ch.ready;
    assign s2_ready         = !s3_valid_reg || s3_ready;
    assign load3            = s2_valid && s2_ready;
    assign load4            = s3_valid_reg && s3_ready;
    assign result_ch.valid   = out_valid_reg;
    assign result_ch.drive   = drive_reg;
    assign result_ch.stopped = stopped_reg;

    // Speed sum, low-speed stop decision and speed clamp.
    always_comb
    begin
        raw = {{10{s2_data.p_err[31]}}, s2_data.p_err} + $signed({2'b00, s2_data.p_int})
            + {{10{s2_data.p_der[31]}}, s2_data.p_der};
        speed = raw[41:4];
        latch_base = !s2_data.restart && stop_reg;
        fire = !latch_base && s2_data.settled
            && (speed < $signed({23'd0, cfg.stop_thr}));
        zero_next = latch_base || fire;
        if (speed > hpid_pkg::SPEED_LIM)
        begin
            speed_clamped = hpid_pkg::SPEED_LIM;
        end
        else if (speed < hpid_pkg::SPEED_LIM_NEG)
        begin
            speed_clamped = hpid_pkg::SPEED_LIM_NEG;
        end
        else
        begin
            speed_clamped = speed[16:0];
        end
    end

    // Scaling by 0.88 and saturation to full drive.
    always_comb
    begin
        scaled_full = speed_reg * hpid_pkg::SCALE_088;
        scaled      = scaled_full[32:16];
        if (zero_reg)
        begin
            drive_next = 16'sd0;
        end
        else if (scaled > hpid_pkg::DRIVE_MAX)
        begin
            drive_next = hpid_pkg::DRIVE_MAX;
        end
        else if (scaled < hpid_pkg::DRIVE_MIN)
        begin
            drive_next = hpid_pkg::DRIVE_MIN;
        end
        else
        begin
            drive_next = scaled[15:0];
        end
    end

    // Stop latch and stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg      <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load3)
            begin
                stop_reg     <= zero_next;
                s3_valid_reg <= 1'b1;
            end
            else if (s3_ready)
            begin
                s3_valid_reg <= 1'b0;
            end
            if (load4)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Speed stage and result register.
    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            speed_reg <= speed_clamped;
            zero_reg  <= zero_next;
        end
        if (load4)
        begin
            drive_reg   <= drive_next;
            stopped_reg <= zero_reg;
        end
    end

endmodule
